>>> rtl/clip_edit_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Clip edit list engine assertion macros
// Concurrent checks on the engine clock, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef CLIP_EDIT_LIST_ENGINE_ASSERT_SVH
`define CLIP_EDIT_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define CEL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("clip edit list engine check failed");
`define CEL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("clip edit list engine check failed");
`else
`define CEL_ASSERT_ALWAYS(lbl, expr)
`define CEL_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types, command codes and defaults of the clip edit list engine.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int TAG_W = 16;
  localparam int MS_W  = 32;

  localparam int          DEF_MAX_CLIPS     = 32;
  localparam logic [31:0] DEF_MAX_SOURCE_MS = 32'hFFFF_FFFF;

  localparam logic [2:0] FUNC_QUERY  = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_MOVE   = 3'd3;
  localparam logic [2:0] FUNC_SPLIT  = 3'd4;
  localparam logic [2:0] FUNC_TRIM   = 3'd5;

  localparam logic REG_TIMELINE_LIMIT   = 1'b0;
  localparam logic REG_SOURCE_DURATION  = 1'b1;

  localparam logic [31:0] RST_TIMELINE_LIMIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_SOURCE_DURATION = 32'h0000_0000;

  typedef struct packed {
    logic [MS_W-1:0]  start;
    logic [MS_W-1:0]  src_in;
    logic [MS_W-1:0]  src_out;
    logic [TAG_W-1:0] tag;
  } clip_t;

  typedef struct packed {
    logic [MS_W-1:0] timeline_limit;
    logic [MS_W-1:0] source_duration;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             mark;
    logic             search;
    logic [TAG_W-1:0] from;
    logic [TAG_W-1:0] extra;
    logic [TAG_W-1:0] tag;
  } alloc_req_t;

  typedef struct packed {
    logic             done;
    logic [TAG_W-1:0] tag;
  } alloc_rsp_t;

endpackage

>>> rtl/cel_clip_ram.sv
// ----------------------------------------------------------------------------
// cel_clip_ram
// Two-bank clip table, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cel_clip_ram #(
  parameter int AW = 5
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW:0]    waddr,
  input  cel_pkg::clip_t wdata,
  input  logic [AW:0]    raddr,
  output cel_pkg::clip_t rdata
);
  import cel_pkg::*;

  localparam int DEPTH = 2 ** (AW + 1);

  clip_t mem [DEPTH];
  clip_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cel_cfg_regs.sv
// ----------------------------------------------------------------------------
// cel_cfg_regs
// APB register file: timeline limit and source duration.
// ----------------------------------------------------------------------------
module cel_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cel_pkg::cfg_t cfg
);
  import cel_pkg::*;

  logic [31:0] limit_r;
  logic [31:0] dur_r;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RST_TIMELINE_LIMIT;
      dur_r   <= RST_SOURCE_DURATION;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TIMELINE_LIMIT:  limit_r <= pwdata;
        REG_SOURCE_DURATION: dur_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMELINE_LIMIT:  prdata = limit_r;
      REG_SOURCE_DURATION: prdata = dur_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg.timeline_limit  = limit_r;
  assign cfg.source_duration = dur_r;

endmodule

>>> rtl/cel_tag_alloc.sv
// ----------------------------------------------------------------------------
// cel_tag_alloc
// Fresh tag search: marks tags in use during a table scan, then walks
// candidates upward from the start tag one per cycle.
// ----------------------------------------------------------------------------
module cel_tag_alloc #(
  parameter int MAX_CLIPS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cel_pkg::alloc_req_t req,
  output cel_pkg::alloc_rsp_t rsp
);
  import cel_pkg::*;

  localparam int K  = MAX_CLIPS + 3;
  localparam int MW = $clog2(K);
  localparam int DW = $clog2(K + 1);

  logic [K-1:0]     mask_r;
  logic [DW-1:0]    d_r;
  logic [TAG_W-1:0] from_r;
  logic [TAG_W-1:0] extra_r;
  logic [TAG_W-1:0] offs;
  logic [TAG_W-1:0] cand;
  logic             free;

  assign offs = req.tag - from_r;
  assign cand = from_r + {{(TAG_W-DW){1'b0}}, d_r};
  assign free = (d_r == DW'(K)) ||
                ((cand != '0) && (cand != extra_r) && !mask_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      d_r     <= '0;
      from_r  <= '0;
      extra_r <= '0;
    end else if (req.start) begin
      mask_r  <= '0;
      d_r     <= '0;
      from_r  <= req.from;
      extra_r <= req.extra;
    end else if (req.mark) begin
      if (offs < TAG_W'(K)) begin
        mask_r[offs[MW-1:0]] <= 1'b1;
      end
    end else if (req.search && !free) begin
      mask_r <= mask_r >> 1;
      d_r    <= d_r + 1'b1;
    end
  end

  assign rsp.done = req.search && free;
  assign rsp.tag  = cand;

endmodule

>>> rtl/clip_edit_list_engine.sv
// A query reads one table entry per cycle. Move, split and trim first scan the
// table to find the clip; each tag search scans it to mark the tags in use,
// then walks the candidates. An edit that passes its checks rebuilds the table
// into the spare bank, splitting clips where needed. One item is taken at a time.
// The result waits in an output register while the next item is taken.
// Reset (synchronous, active low) empties the table and sets the next tag to one.
// ----------------------------------------------------------------------------
// clip_edit_list_engine
// Sorted clip table with query, insert, remove, move, split and trim commands.
// ----------------------------------------------------------------------------
module clip_edit_list_engine #(
  parameter int          MAX_CLIPS     = cel_pkg::DEF_MAX_CLIPS,
  parameter logic [31:0] MAX_SOURCE_MS = cel_pkg::DEF_MAX_SOURCE_MS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_clip_tag,
  input  logic [31:0] in_time_ms,
  input  logic [31:0] in_start_ms,
  input  logic [31:0] in_end_ms,
  input  logic [31:0] in_source_in_ms,
  input  logic [31:0] in_source_out_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_source_time_ms,
  output logic        out_playing,
  output logic [15:0] out_hit_tag,
  output logic [15:0] out_new_tag,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cel_pkg::*;

  `include "clip_edit_list_engine_assert.svh"

  localparam int AW = $clog2(MAX_CLIPS);
  localparam int CW = $clog2(MAX_CLIPS + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_QUERY  = 13'b0000000000010,
    S_QCLAMP = 13'b0000000000100,
    S_FIND   = 13'b0000000001000,
    S_PREP   = 13'b0000000010000,
    S_TRIM2  = 13'b0000000100000,
    S_TRIM3  = 13'b0000001000000,
    S_TRIM4  = 13'b0000010000000,
    S_CHECK  = 13'b0000100000000,
    S_ASCAN  = 13'b0001000000000,
    S_ASRCH  = 13'b0010000000000,
    S_BUILD  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    AP_FRESH = 3'b001,
    AP_RT    = 3'b010,
    AP_SPLIT = 3'b100
  } phase_t;

  cfg_t       cfg;
  alloc_req_t areq;
  alloc_rsp_t arsp;
  clip_t      rdata;
  clip_t      wdata;
  logic       ram_we;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   next_tag_r, next_tag_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [15:0]   tag_r, tag_nxt;
  logic [31:0]   time_r, time_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   end_r, end_nxt;
  logic [31:0]   ins_start_r, ins_start_nxt;
  logic [31:0]   ins_in_r, ins_in_nxt;
  logic [31:0]   ins_out_r, ins_out_nxt;
  logic [32:0]   cend_r, cend_nxt;
  logic [15:0]   cursor0_r, cursor0_nxt;
  logic [15:0]   rt_r, rt_nxt;
  logic          rt_used_r, rt_used_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic          sub_r, sub_nxt;
  logic          placed_r, placed_nxt;
  logic          over_r, over_nxt;
  logic          found_r, found_nxt;
  clip_t         fclip_r, fclip_nxt;
  logic signed [33:0] lo_r, lo_nxt;
  logic signed [33:0] hi_r, hi_nxt;
  logic signed [33:0] ts_r, ts_nxt;
  logic signed [33:0] te_r, te_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [31:0]   res_src_r, res_src_nxt;
  logic          res_play_r, res_play_nxt;
  logic [15:0]   res_hit_r, res_hit_nxt;
  logic [15:0]   res_new_r, res_new_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [31:0]   out_src_r, out_src_nxt;
  logic          out_play_r, out_play_nxt;
  logic [15:0]   out_hit_r, out_hit_nxt;
  logic [15:0]   out_new_r, out_new_nxt;

  logic [32:0] e_end;
  logic [32:0] f_end;
  logic [32:0] t33;
  logic [32:0] cend_calc;
  logic        e_last;
  logic        ovl;
  logic        mode_rm;
  logic        mode_sp;
  logic        mode_ins;
  logic        pv;
  logic        last_sub;
  logic        do_emit;
  logic        build_ok;
  clip_t       p;
  clip_t       new_clip;
  logic [31:0] dur;
  logic [31:0] lim_room;
  logic signed [33:0] hi_raw;
  logic signed [33:0] start_s;
  logic signed [33:0] end_s;

  cel_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cel_clip_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({~bank_r, wr_idx_r[AW-1:0]}),
    .wdata (wdata),
    .raddr ({bank_nxt, rd_idx_nxt[AW-1:0]}),
    .rdata (rdata)
  );

  cel_tag_alloc #(.MAX_CLIPS(MAX_CLIPS)) u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign in_ready = (state_r == S_IDLE);

  assign e_end     = {1'b0, rdata.start} + {1'b0, rdata.src_out} - {1'b0, rdata.src_in};
  assign f_end     = {1'b0, fclip_r.start} + {1'b0, fclip_r.src_out} - {1'b0, fclip_r.src_in};
  assign t33       = {1'b0, time_r};
  assign cend_calc = {1'b0, ins_start_r} + {1'b0, ins_out_r} - {1'b0, ins_in_r};
  assign e_last    = ((rd_idx_r + 1'b1) == count_r);
  assign ovl       = !((e_end <= {1'b0, ins_start_r}) || ({1'b0, rdata.start} >= cend_r));
  assign mode_rm   = (func_r == FUNC_REMOVE);
  assign mode_sp   = (func_r == FUNC_SPLIT);
  assign mode_ins  = !mode_rm && !mode_sp;
  assign new_clip  = '{start: ins_start_r, src_in: ins_in_r, src_out: ins_out_r, tag: tag_r};
  assign build_ok  = !over_r && (!mode_rm || found_r);
  assign dur       = fclip_r.src_out - fclip_r.src_in;
  assign lim_room  = cfg.timeline_limit - dur;
  assign hi_raw    = $signed({2'b00, fclip_r.start}) + $signed({2'b00, cfg.source_duration})
                     - $signed({2'b00, fclip_r.src_in});
  assign start_s   = $signed({2'b00, start_r});
  assign end_s     = $signed({2'b00, end_r});

  // piece of the current table entry for the rebuild
  always_comb begin
    pv       = 1'b0;
    p        = rdata;
    last_sub = 1'b1;
    if (mode_ins) begin
      if (!sub_r) begin
        pv       = (rdata.tag != tag_r) && (!ovl || (rdata.start < ins_start_r));
        p.src_out = ovl ? rdata.src_in + (ins_start_r - rdata.start) : rdata.src_out;
        last_sub = 1'b0;
      end else begin
        pv       = (rdata.tag != tag_r) && ovl && (e_end > cend_r);
        p.start  = cend_r[31:0];
        p.src_in = rdata.src_in + (cend_r[31:0] - rdata.start);
        p.tag    = rt_r;
      end
    end else if (mode_rm) begin
      pv = (rdata.tag != tag_r);
    end else begin
      pv = 1'b1;
      if (rdata.tag == tag_r) begin
        if (!sub_r) begin
          p.src_out = rdata.src_in + (time_r - rdata.start);
          last_sub  = 1'b0;
        end else begin
          p.start  = time_r;
          p.src_in = rdata.src_in + (time_r - rdata.start);
          p.tag    = rt_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    bank_nxt      = bank_r;
    count_nxt     = count_r;
    next_tag_nxt  = next_tag_r;
    func_nxt      = func_r;
    tag_nxt       = tag_r;
    time_nxt      = time_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    ins_start_nxt = ins_start_r;
    ins_in_nxt    = ins_in_r;
    ins_out_nxt   = ins_out_r;
    cend_nxt      = cend_r;
    cursor0_nxt   = cursor0_r;
    rt_nxt        = rt_r;
    rt_used_nxt   = rt_used_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    sub_nxt       = sub_r;
    placed_nxt    = placed_r;
    over_nxt      = over_r;
    found_nxt     = found_r;
    fclip_nxt     = fclip_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ts_nxt        = ts_r;
    te_nxt        = te_r;
    res_ok_nxt    = res_ok_r;
    res_src_nxt   = res_src_r;
    res_play_nxt  = res_play_r;
    res_hit_nxt   = res_hit_r;
    res_new_nxt   = res_new_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_src_nxt   = out_src_r;
    out_play_nxt  = out_play_r;
    out_hit_nxt   = out_hit_r;
    out_new_nxt   = out_new_r;
    areq          = '0;
    ram_we        = 1'b0;
    wdata         = new_clip;
    do_emit       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt      = in_func;
          tag_nxt       = in_clip_tag;
          time_nxt      = in_time_ms;
          start_nxt     = in_start_ms;
          end_nxt       = in_end_ms;
          ins_start_nxt = in_start_ms;
          ins_in_nxt    = in_source_in_ms;
          ins_out_nxt   = in_source_out_ms;
          cursor0_nxt   = next_tag_r;
          res_ok_nxt    = 1'b0;
          res_src_nxt   = '0;
          res_play_nxt  = 1'b0;
          res_hit_nxt   = '0;
          res_new_nxt   = '0;
          rd_idx_nxt    = '0;
          wr_idx_nxt    = '0;
          sub_nxt       = 1'b0;
          placed_nxt    = 1'b0;
          over_nxt      = 1'b0;
          found_nxt     = 1'b0;
          rt_used_nxt   = 1'b0;
          case (in_func)
            FUNC_QUERY: begin
              if (count_r == '0) begin
                res_ok_nxt = 1'b1;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_QUERY;
              end
            end
            FUNC_INSERT: begin
              if (in_clip_tag == '0) begin
                areq.start = 1'b1;
                areq.from  = next_tag_r;
                areq.extra = '0;
                phase_nxt  = AP_FRESH;
                state_nxt  = (count_r == '0) ? S_ASRCH : S_ASCAN;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            FUNC_REMOVE: begin
              state_nxt = S_BUILD;
            end
            FUNC_MOVE, FUNC_SPLIT, FUNC_TRIM: begin
              state_nxt = (count_r == '0) ? S_DONE : S_FIND;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_QUERY: begin
        if (t33 < {1'b0, rdata.start}) begin
          if (rd_idx_r == '0) begin
            res_src_nxt = rdata.src_in;
          end
          state_nxt = S_QCLAMP;
        end else if (t33 < e_end) begin
          res_src_nxt  = rdata.src_in + (time_r - rdata.start);
          res_play_nxt = 1'b1;
          res_hit_nxt  = rdata.tag;
          state_nxt    = S_QCLAMP;
        end else begin
          res_src_nxt = rdata.src_out - 32'd1;
          if (e_last) begin
            state_nxt = S_QCLAMP;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
      end

      S_QCLAMP: begin
        if ((cfg.source_duration != '0) && (res_src_r > cfg.source_duration - 32'd1)) begin
          res_src_nxt = cfg.source_duration - 32'd1;
        end
        res_ok_nxt = 1'b1;
        state_nxt  = S_DONE;
      end

      S_FIND: begin
        if (rdata.tag == tag_r) begin
          fclip_nxt = rdata;
          state_nxt = S_PREP;
        end else if (e_last) begin
          state_nxt = S_DONE;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end

      S_PREP: begin
        case (func_r)
          FUNC_MOVE: begin
            if (dur > cfg.timeline_limit) begin
              state_nxt = S_DONE;
            end else begin
              ins_start_nxt = (start_r > lim_room) ? lim_room : start_r;
              ins_in_nxt    = fclip_r.src_in;
              ins_out_nxt   = fclip_r.src_out;
              state_nxt     = S_CHECK;
            end
          end
          FUNC_SPLIT: begin
            if (!((t33 > {1'b0, fclip_r.start}) && (t33 < f_end)) ||
                (count_r == CW'(MAX_CLIPS))) begin
              state_nxt = S_DONE;
            end else begin
              areq.start = 1'b1;
              areq.from  = next_tag_r;
              areq.extra = '0;
              phase_nxt  = AP_SPLIT;
              rd_idx_nxt = '0;
              state_nxt  = S_ASCAN;
            end
          end
          FUNC_TRIM: begin
            if ((cfg.source_duration == '0) || (cfg.timeline_limit == '0)) begin
              state_nxt = S_DONE;
            end else begin
              lo_nxt = (fclip_r.start >= fclip_r.src_in) ?
                       $signed({2'b00, fclip_r.start - fclip_r.src_in}) : '0;
              hi_nxt = (hi_raw > $signed({2'b00, cfg.timeline_limit})) ?
                       $signed({2'b00, cfg.timeline_limit}) : hi_raw;
              state_nxt = S_TRIM2;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_TRIM2: begin
        if (hi_r <= lo_r) begin
          state_nxt = S_DONE;
        end else begin
          ts_nxt = (start_s < lo_r) ? lo_r :
                   ((start_s > hi_r - 34'sd1) ? hi_r - 34'sd1 : start_s);
          state_nxt = S_TRIM3;
        end
      end

      S_TRIM3: begin
        te_nxt = (end_s < ts_r + 34'sd1) ? ts_r + 34'sd1 :
                 ((end_s > hi_r) ? hi_r : end_s);
        state_nxt = S_TRIM4;
      end

      S_TRIM4: begin
        ins_start_nxt = ts_r[31:0];
        ins_in_nxt    = fclip_r.src_in + ts_r[31:0] - fclip_r.start;
        ins_out_nxt   = fclip_r.src_in + te_r[31:0] - fclip_r.start;
        state_nxt     = S_CHECK;
      end

      S_CHECK: begin
        if ((ins_out_r <= ins_in_r) || (ins_out_r > MAX_SOURCE_MS) ||
            (cend_calc > {1'b0, cfg.timeline_limit})) begin
          state_nxt = S_DONE;
        end else begin
          cend_nxt   = cend_calc;
          areq.start = 1'b1;
          areq.from  = cursor0_r;
          areq.extra = tag_r;
          phase_nxt  = AP_RT;
          rd_idx_nxt = '0;
          state_nxt  = (count_r == '0) ? S_ASRCH : S_ASCAN;
        end
      end

      S_ASCAN: begin
        areq.mark = 1'b1;
        areq.tag  = rdata.tag;
        if (e_last) begin
          state_nxt = S_ASRCH;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end

      S_ASRCH: begin
        areq.search = 1'b1;
        if (arsp.done) begin
          rd_idx_nxt = '0;
          case (phase_r)
            AP_FRESH: begin
              tag_nxt     = arsp.tag;
              cursor0_nxt = arsp.tag + 16'd1;
              state_nxt   = S_CHECK;
            end
            AP_RT, AP_SPLIT: begin
              rt_nxt    = arsp.tag;
              state_nxt = S_BUILD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_BUILD: begin
        if (rd_idx_r == count_r) begin
          if (mode_ins && !placed_r) begin
            do_emit    = 1'b1;
            wdata      = new_clip;
            placed_nxt = 1'b1;
          end else begin
            res_ok_nxt = build_ok;
            if (build_ok) begin
              bank_nxt  = ~bank_r;
              count_nxt = wr_idx_r;
              if (mode_sp) begin
                next_tag_nxt = rt_r + 16'd1;
                res_new_nxt  = rt_r;
              end else if (mode_ins) begin
                next_tag_nxt = rt_used_r ? rt_r + 16'd1 : cursor0_r;
                res_new_nxt  = (func_r == FUNC_INSERT) ? tag_r : '0;
              end
            end
            state_nxt = S_DONE;
          end
        end else if (pv && mode_ins && !placed_r && (p.start > ins_start_r)) begin
          do_emit    = 1'b1;
          wdata      = new_clip;
          placed_nxt = 1'b1;
        end else begin
          if (pv) begin
            do_emit = 1'b1;
            wdata   = p;
            if (mode_ins && sub_r) begin
              rt_used_nxt = 1'b1;
            end
          end else if (mode_rm) begin
            found_nxt = 1'b1;
          end
          if (last_sub) begin
            sub_nxt    = 1'b0;
            rd_idx_nxt = rd_idx_r + 1'b1;
          end else begin
            sub_nxt = 1'b1;
          end
        end
        if (do_emit) begin
          if (wr_idx_r == CW'(MAX_CLIPS)) begin
            over_nxt = 1'b1;
          end else begin
            ram_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_src_nxt   = res_src_r;
          out_play_nxt  = res_play_r;
          out_hit_nxt   = res_hit_r;
          out_new_nxt   = res_new_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= AP_FRESH;
      bank_r      <= 1'b0;
      count_r     <= '0;
      next_tag_r  <= 16'd1;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      sub_r       <= 1'b0;
      placed_r    <= 1'b0;
      over_r      <= 1'b0;
      found_r     <= 1'b0;
      rt_used_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      next_tag_r  <= next_tag_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      sub_r       <= sub_nxt;
      placed_r    <= placed_nxt;
      over_r      <= over_nxt;
      found_r     <= found_nxt;
      rt_used_r   <= rt_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    tag_r       <= tag_nxt;
    time_r      <= time_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    ins_start_r <= ins_start_nxt;
    ins_in_r    <= ins_in_nxt;
    ins_out_r   <= ins_out_nxt;
    cend_r      <= cend_nxt;
    cursor0_r   <= cursor0_nxt;
    rt_r        <= rt_nxt;
    fclip_r     <= fclip_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ts_r        <= ts_nxt;
    te_r        <= te_nxt;
    res_ok_r    <= res_ok_nxt;
    res_src_r   <= res_src_nxt;
    res_play_r  <= res_play_nxt;
    res_hit_r   <= res_hit_nxt;
    res_new_r   <= res_new_nxt;
    out_ok_r    <= out_ok_nxt;
    out_src_r   <= out_src_nxt;
    out_play_r  <= out_play_nxt;
    out_hit_r   <= out_hit_nxt;
    out_new_r   <= out_new_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_source_time_ms = out_src_r;
  assign out_playing        = out_play_r;
  assign out_hit_tag        = out_hit_r;
  assign out_new_tag        = out_new_r;

  `CEL_ASSERT_ALWAYS(a_count_range, (count_r <= CW'(MAX_CLIPS)) && (wr_idx_r <= CW'(MAX_CLIPS)))
  `CEL_ASSERT_ALWAYS(a_fail_clean, !out_valid_r || out_ok_r || ((out_new_r == '0) && !out_play_r && (out_src_r == '0)))
  `CEL_ASSERT_NEXT(a_bank_hold, state_r != S_BUILD, $stable(bank_r) && $stable(count_r))
  `CEL_ASSERT_NEXT(a_done_delivers, (state_r == S_DONE) && !out_valid_r, out_valid_r && (state_r == S_IDLE))

endmodule

>>> sim/tb_clip_edit_list_engine.sv
// ----------------------------------------------------------------------------
// Clip edit list engine testbench
// Feeds query and edit commands through the valid/ready input channel and
// predicts every result from a local copy of the clip table. Results are
// compared field by field in order. Register settings change between phases
// while the engine is idle. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_clip_edit_list_engine;
  import cel_pkg::*;

  localparam int NCLIP = 32;
  localparam int TCAP  = NCLIP + 2;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] tag;
    logic [31:0] time_ms;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    logic [31:0] src_in;
    logic [31:0] src_out;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] src_time;
    logic        playing;
    logic [15:0] hit_tag;
    logic [15:0] new_tag;
  } answer_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, in_ready, out_valid;
  cmd_t cur = '0;
  logic out_ok, out_playing;
  logic [31:0] out_source_time_ms, prdata;
  logic [15:0] out_hit_tag, out_new_tag;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  cmd_t    pend[$];
  answer_t answers[$];
  bit      failed = 0;
  bit      quiet = 0;
  int      span = 20000;

  // table copy
  logic [31:0] tl_start[NCLIP], tl_in[NCLIP], tl_out[NCLIP];
  logic [15:0] tl_tag[NCLIP];
  int          tl_cnt = 0;
  logic [15:0] tl_next = 16'd1;
  logic [31:0] lim_ms = RST_TIMELINE_LIMIT, dur_ms = RST_SOURCE_DURATION;
  logic [31:0] tw_start[TCAP], tw_in[TCAP], tw_out[TCAP];
  logic [15:0] tw_tag[TCAP];
  int          tw_n;
  bit          tw_over;

  clip_edit_list_engine dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_func(cur.func), .in_clip_tag(cur.tag), .in_time_ms(cur.time_ms),
    .in_start_ms(cur.start_ms), .in_end_ms(cur.end_ms),
    .in_source_in_ms(cur.src_in), .in_source_out_ms(cur.src_out),
    .out_valid, .out_ready, .out_ok, .out_source_time_ms, .out_playing,
    .out_hit_tag, .out_new_tag,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] clip_end(int i);
    return {32'd0, tl_start[i]} + tl_out[i] - tl_in[i];
  endfunction

  function automatic int tag_slot(logic [15:0] t);
    for (int i = 0; i < tl_cnt; i++)
      if (tl_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic logic [15:0] fresh_tag(logic [15:0] from, logic [15:0] extra);
    logic [15:0] t;
    t = from;
    for (int k = 0; k < NCLIP + 3; k++) begin
      if (t != 0 && t != extra && tag_slot(t) < 0) return t;
      t = t + 16'd1;
    end
    return t;
  endfunction

  function automatic void stage(logic [31:0] s, logic [31:0] i, logic [31:0] o,
                                logic [15:0] t);
    if (tw_n >= TCAP) begin
      tw_over = 1;
      return;
    end
    tw_start[tw_n] = s; tw_in[tw_n] = i; tw_out[tw_n] = o; tw_tag[tw_n] = t;
    tw_n++;
  endfunction

  function automatic bit place_clip(logic [15:0] tag_i, logic [63:0] st,
                                    logic [63:0] si, logic [63:0] so,
                                    output logic [15:0] tag_o);
    logic [15:0] cursor, rt, tg;
    logic [63:0] cend, os, oe;
    int pos;
    cursor = tl_next;
    tg = tag_i;
    tag_o = 0;
    tw_n = 0;
    tw_over = 0;
    if (tg == 0) begin
      tg = fresh_tag(cursor, 16'd0);
      cursor = tg + 16'd1;
    end
    if (so <= si || so > 64'hFFFF_FFFF) return 0;
    cend = st + (so - si);
    if (cend > {32'd0, lim_ms}) return 0;
    for (int i = 0; i < tl_cnt; i++) begin
      os = tl_start[i];
      oe = clip_end(i);
      if (tl_tag[i] == tg) continue;
      if (oe <= st || os >= cend) begin
        stage(tl_start[i], tl_in[i], tl_out[i], tl_tag[i]);
        continue;
      end
      if (os < st) stage(tl_start[i], tl_in[i], tl_in[i] + 32'(st - os), tl_tag[i]);
      if (oe > cend) begin
        rt = fresh_tag(cursor, tg);
        cursor = rt + 16'd1;
        stage(32'(cend), tl_in[i] + 32'(cend - os), tl_out[i], rt);
      end
    end
    if (tw_over || tw_n + 1 > NCLIP) return 0;
    pos = tw_n;
    for (int i = 0; i < tw_n; i++)
      if ({32'd0, tw_start[i]} > st) begin
        pos = i;
        break;
      end
    for (int i = tw_n; i > pos; i--) begin
      tw_start[i] = tw_start[i-1]; tw_in[i] = tw_in[i-1];
      tw_out[i] = tw_out[i-1]; tw_tag[i] = tw_tag[i-1];
    end
    tw_start[pos] = 32'(st); tw_in[pos] = 32'(si); tw_out[pos] = 32'(so);
    tw_tag[pos] = tg;
    tw_n++;
    for (int i = 0; i < tw_n; i++) begin
      tl_start[i] = tw_start[i]; tl_in[i] = tw_in[i];
      tl_out[i] = tw_out[i]; tl_tag[i] = tw_tag[i];
    end
    tl_cnt = tw_n;
    tl_next = cursor;
    tag_o = tg;
    return 1;
  endfunction

  function automatic answer_t run_cmd(cmd_t c);
    answer_t a;
    logic [63:0] src, t, d, s;
    logic [15:0] nt, rt;
    int f, pv;
    longint cs, ci, lo, hi, ts, te, sv;
    a = '0;
    nt = 0;
    f = tag_slot(c.tag);
    case (c.func)
      FUNC_QUERY: begin
        a.ok = 1;
        src = 0;
        t = c.time_ms;
        pv = -1;
        if (tl_cnt > 0) begin
          for (int i = 0; i < tl_cnt; i++) begin
            if (t < tl_start[i]) begin
              src = (pv >= 0) ? {32'd0, tl_out[pv]} - 1 : {32'd0, tl_in[i]};
              break;
            end
            if (t < clip_end(i)) begin
              src = {32'd0, tl_in[i]} + (t - tl_start[i]);
              a.playing = 1;
              a.hit_tag = tl_tag[i];
              break;
            end
            pv = i;
            src = {32'd0, tl_out[i]} - 1;
          end
          if (dur_ms > 0 && src > {32'd0, dur_ms} - 1) src = {32'd0, dur_ms} - 1;
        end
        a.src_time = 32'(src);
      end
      FUNC_INSERT: a.ok = place_clip(c.tag, c.start_ms, c.src_in, c.src_out, nt);
      FUNC_REMOVE:
        if (f >= 0) begin
          for (int k = f; k + 1 < tl_cnt; k++) begin
            tl_start[k] = tl_start[k+1]; tl_in[k] = tl_in[k+1];
            tl_out[k] = tl_out[k+1]; tl_tag[k] = tl_tag[k+1];
          end
          tl_cnt--;
          a.ok = 1;
        end
      FUNC_MOVE:
        if (f >= 0) begin
          d = {32'd0, tl_out[f]} - tl_in[f];
          if (d <= lim_ms) begin
            s = c.start_ms;
            if (s > lim_ms - d) s = lim_ms - d;
            a.ok = place_clip(c.tag, s, tl_in[f], tl_out[f], rt);
          end
        end
      FUNC_SPLIT:
        if (f >= 0 && c.time_ms > tl_start[f] && {32'd0, c.time_ms} < clip_end(f)
            && tl_cnt + 1 <= NCLIP) begin
          rt = fresh_tag(tl_next, 16'd0);
          for (int k = tl_cnt; k > f + 1; k--) begin
            tl_start[k] = tl_start[k-1]; tl_in[k] = tl_in[k-1];
            tl_out[k] = tl_out[k-1]; tl_tag[k] = tl_tag[k-1];
          end
          tl_out[f+1] = tl_out[f];
          tl_out[f] = tl_in[f] + (c.time_ms - tl_start[f]);
          tl_in[f+1] = tl_out[f];
          tl_start[f+1] = c.time_ms;
          tl_tag[f+1] = rt;
          tl_cnt++;
          tl_next = rt + 16'd1;
          nt = rt;
          a.ok = 1;
        end
      FUNC_TRIM:
        if (dur_ms != 0 && lim_ms != 0 && f >= 0) begin
          cs = tl_start[f];
          ci = tl_in[f];
          lo = cs - ci;
          if (lo < 0) lo = 0;
          hi = cs + longint'(dur_ms) - ci;
          if (hi > longint'(lim_ms)) hi = lim_ms;
          if (hi > lo) begin
            ts = c.start_ms;
            te = c.end_ms;
            ts = ts < lo ? lo : (ts > hi - 1 ? hi - 1 : ts);
            te = te < ts + 1 ? ts + 1 : (te > hi ? hi : te);
            sv = ci + ts - cs;
            a.ok = place_clip(c.tag, ts, sv, sv + te - ts, rt);
          end
        end
      default: ;
    endcase
    if (a.ok && (c.func == FUNC_INSERT || c.func == FUNC_SPLIT)) a.new_tag = nt;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) answers.push_back(run_cmd(cur));
      if (pend.size() > 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
        cur <= pend.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver with one long hold-off
  int rx_cyc = 0, rx_hold = 0;
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc == 3000) rx_hold <= 600;
    else if (rx_hold > 0) rx_hold <= rx_hold - 1;
    if (!rst_n || rx_cyc == 3000 || rx_hold > 1) out_ready <= 0;
    else out_ready <= quiet || $urandom_range(0, 99) >= 17;
  end

  task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %0h got %0h", nm, e, a);
      failed = 1;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (answers.size() == 0) begin
        $error("result with no command outstanding");
        failed = 1;
      end else begin
        e = answers.pop_front();
        check_field("ok", e.ok, out_ok);
        check_field("source_time_ms", e.src_time, out_source_time_ms);
        check_field("playing", e.playing, out_playing);
        check_field("hit_tag", e.hit_tag, out_hit_tag);
        check_field("new_tag", e.new_tag, out_new_tag);
      end
    end
  end

  task automatic drain();
    wait (pend.size() == 0 && !in_valid && answers.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_TIMELINE_LIMIT) lim_ms = v;
    else dur_ms = v;
  endtask

  function automatic logic [31:0] pick_ms();
    return ($urandom_range(0, 99) < 10) ? $urandom() : $urandom_range(0, span);
  endfunction

  function automatic logic [15:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && tl_cnt > 0) return tl_tag[$urandom_range(0, tl_cnt - 1)];
    if (r < 90) return $urandom();
    return $urandom_range(0, 3);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.func = FUNC_QUERY;
    c.tag = pick_tag();
    c.time_ms = pick_ms();
    c.start_ms = pick_ms();
    c.end_ms = $urandom_range(0, 99) < 70 ? c.start_ms + $urandom_range(0, 3000) : pick_ms();
    c.src_in = $urandom_range(0, 99) < 15 ? $urandom() : $urandom_range(0, 4000);
    c.src_out = $urandom_range(0, 99) < 10 ? $urandom() : c.src_in + $urandom_range(0, 2500);
    r = $urandom_range(0, 99);
    if (r < 35) c.func = FUNC_QUERY;
    else if (r < 65) begin
      c.func = FUNC_INSERT;
      if ($urandom_range(0, 3) != 0) c.tag = 0;
    end
    else if (r < 72) c.func = FUNC_REMOVE;
    else if (r < 80) c.func = FUNC_MOVE;
    else if (r < 89) begin
      c.func = FUNC_SPLIT;
      if (c.tag != 0 && tag_slot(c.tag) >= 0 && $urandom_range(0, 3) != 0)
        c.time_ms = tl_start[tag_slot(c.tag)] + $urandom_range(0, 2500);
    end
    else if (r < 98) c.func = FUNC_TRIM;
    else c.func = 3'($urandom_range(6, 7));
    return c;
  endfunction

  task automatic feed(int n);
    repeat (n) begin
      wait (pend.size() < 2);
      pend.push_back(rand_cmd());
      @(posedge clk);
    end
  endtask

  function automatic cmd_t mk(logic [2:0] f, logic [15:0] t, logic [31:0] tm,
                              logic [31:0] s, logic [31:0] e, logic [31:0] i,
                              logic [31:0] o);
    cmd_t c;
    c.func = f; c.tag = t; c.time_ms = tm; c.start_ms = s; c.end_ms = e;
    c.src_in = i; c.src_out = o;
    return c;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    pend.push_back(mk(FUNC_QUERY, 0, 500, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_INSERT, 0, 0, 1000, 0, 100, 1100));
    pend.push_back(mk(FUNC_INSERT, 0, 0, 3000, 0, 0, 500));
    pend.push_back(mk(FUNC_INSERT, 0, 0, 1200, 0, 50, 150));
    pend.push_back(mk(FUNC_QUERY, 0, 10, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_QUERY, 0, 1250, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_QUERY, 0, 2500, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_INSERT, 0, 0, 0, 0, 500, 500));
    pend.push_back(mk(FUNC_INSERT, 0, 0, 32'hFFFF_FFFF, 0, 0, 2));
    pend.push_back(mk(FUNC_INSERT, 16'hFFFF, 0, 32'hFFFF_FFFE, 0, 32'hFFFF_FFFE,
                      32'hFFFF_FFFF));
    pend.push_back(mk(FUNC_SPLIT, 1, 1500, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_SPLIT, 1, 1000, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_REMOVE, 0, 0, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_REMOVE, 16'h7777, 0, 0, 0, 0, 0));
    pend.push_back(mk(FUNC_MOVE, 2, 0, 32'hFFFF_FFFF, 0, 0, 0));
    pend.push_back(mk(FUNC_TRIM, 1, 0, 900, 1300, 0, 0));
    pend.push_back(mk(3'd6, 1, 1, 1, 1, 1, 2));
    pend.push_back(mk(3'd7, 16'hFFFF, '1, '1, '1, '1, '1));
    pend.push_back(mk(FUNC_REMOVE, 1, 0, 0, 0, 0, 0));
    feed(150);
    drain();
    reg_write(REG_TIMELINE_LIMIT, 32'd20000);
    reg_write(REG_SOURCE_DURATION, 32'd5000);
    pend.push_back(mk(FUNC_TRIM, tl_cnt > 0 ? tl_tag[0] : 16'd1, 0, 0, '1, 0, 0));
    feed(200);
    drain();
    reg_write(REG_TIMELINE_LIMIT, 32'd1);
    reg_write(REG_SOURCE_DURATION, 32'hFFFF_FFFF);
    span = 3;
    feed(60);
    drain();
    reg_write(REG_TIMELINE_LIMIT, 32'hFFFF_FFFF);
    reg_write(REG_SOURCE_DURATION, 32'd1);
    span = 20000;
    feed(100);
    drain();
    reg_write(REG_TIMELINE_LIMIT, 32'd50000);
    reg_write(REG_SOURCE_DURATION, 32'd30000);
    span = 50000;
    quiet = 1;
    feed(80);
    quiet = 0;
    feed(100);
    drain();
    if (!failed && answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
